### design/jsu_pkg.sv
package jsu_pkg;

   // result kinds on the rsp_result_kind port
   localparam logic [1:0] KIND_DATA  = 2'd0;
   localparam logic [1:0] KIND_DONE  = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   // default depth of the run queue between parser and serializer
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // what follows the data bytes of one run
   typedef enum logic [1:0] {
      TAIL_NONE,
      TAIL_DONE,
      TAIL_ERROR
   } tail_type;

   // all results caused by one input word
   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [2:0]      nbytes;
      tail_type        tail;
   } run_type;

endpackage

### design/json_string_unescape_utf8.sv
// Streaming JSON string decoder: push the raw bytes of the text with
// req_start_of_string on the opening quote, and pop decoded UTF-8 bytes, a done
// word on the closing quote, or one error word on a malformed or unclosed string;
// rsp_last_of_run marks the final word caused by each input byte. A parser stage
// takes one byte per cycle while the run queue is not full and turns it into a
// run of zero to five result words held in a run queue of QUEUE_DEPTH entries;
// a serializer hands out one word per cycle while popped. Sustained input rate
// is one byte per cycle while runs are at most one word and each is popped at
// once; multi-word runs occupy the output and fill the run queue, raising req_full.
module json_string_unescape_utf8
   import jsu_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic [7:0] req_in_byte,
   input  logic       req_start_of_string,
   input  logic       req_end_of_text,
   input  logic       req_push,
   output logic       req_full,
   output logic [7:0] rsp_out_byte,
   output logic [1:0] rsp_result_kind,
   output logic       rsp_last_of_run,
   output logic       rsp_empty,
   input  logic       rsp_pop
);

   logic    accept;
   logic    run_push;
   run_type run;
   run_type head;
   logic    head_pop;

   assign accept = req_push && !req_full;

   jsu_front u_front (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .in_byte         (req_in_byte),
      .start_of_string (req_start_of_string),
      .end_of_text     (req_end_of_text),
      .run_push        (run_push),
      .run             (run)
   );

   jsu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (run_push),
      .push_run (run),
      .full     (req_full),
      .pop      (head_pop),
      .empty    (rsp_empty),
      .head     (head)
   );

   jsu_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .head_empty  (rsp_empty),
      .head_pop    (head_pop),
      .out_byte    (rsp_out_byte),
      .result_kind (rsp_result_kind),
      .last_of_run (rsp_last_of_run),
      .pop         (rsp_pop)
   );

endmodule

### design/jsu_front.sv
module jsu_front
   import jsu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] in_byte,
   input  logic       start_of_string,
   input  logic       end_of_text,
   output logic       run_push,
   output run_type    run
);

   typedef enum logic [3:0] {
      PH_HALT,
      PH_BODY,
      PH_ESC,
      PH_HEX1,
      PH_NEED_BS,
      PH_NEED_U,
      PH_HEX2
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [15:0] acc_ff, acc_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic [9:0]  hs_ff, hs_in;

   logic [15:0] acc_new;
   logic        digit_ok;
   logic [3:0]  digit;

   function automatic run_type utf8_run(input logic [20:0] cp);
      run_type r;
      r = '0;
      r.tail = TAIL_NONE;
      if (cp <= 21'h7f) begin
         r.bytes[0] = cp[7:0];
         r.nbytes   = 3'd1;
      end else if (cp <= 21'h7ff) begin
         r.bytes[0] = 8'hc0 | {3'b0, cp[10:6]};
         r.bytes[1] = 8'h80 | {2'b0, cp[5:0]};
         r.nbytes   = 3'd2;
      end else if (cp <= 21'hffff) begin
         r.bytes[0] = 8'he0 | {4'b0, cp[15:12]};
         r.bytes[1] = 8'h80 | {2'b0, cp[11:6]};
         r.bytes[2] = 8'h80 | {2'b0, cp[5:0]};
         r.nbytes   = 3'd3;
      end else begin
         r.bytes[0] = 8'hf0 | {5'b0, cp[20:18]};
         r.bytes[1] = 8'h80 | {2'b0, cp[17:12]};
         r.bytes[2] = 8'h80 | {2'b0, cp[11:6]};
         r.bytes[3] = 8'h80 | {2'b0, cp[5:0]};
         r.nbytes   = 3'd4;
      end
      return r;
   endfunction

   function automatic run_type one_byte(input logic [7:0] b);
      run_type r;
      r = '0;
      r.tail     = TAIL_NONE;
      r.bytes[0] = b;
      r.nbytes   = 3'd1;
      return r;
   endfunction

   // decode one hex digit
   always_comb begin
      digit_ok = 1'b1;
      digit    = 4'd0;
      if (in_byte inside {["0":"9"]}) begin
         digit = 4'(in_byte - 8'h30);
      end else if (in_byte inside {["a":"f"]}) begin
         digit = 4'(in_byte - 8'h57);
      end else if (in_byte inside {["A":"F"]}) begin
         digit = 4'(in_byte - 8'h37);
      end else begin
         digit_ok = 1'b0;
      end
   end

   assign acc_new = {acc_ff[11:0], digit};

   // parse the word and build its run
   always_comb begin
      phase_in = phase_ff;
      acc_in   = acc_ff;
      cnt_in   = cnt_ff;
      hs_in    = hs_ff;
      run      = '0;
      run.tail = TAIL_NONE;
      if (start_of_string) begin
         acc_in = '0;
         cnt_in = '0;
         hs_in  = '0;
         if (in_byte == "\"") begin
            phase_in = PH_BODY;
         end else begin
            phase_in = PH_HALT;
            run.tail = TAIL_ERROR;
         end
      end else begin
         case (phase_ff)
            PH_BODY: begin
               if (in_byte == "\"") begin
                  phase_in = PH_HALT;
                  run.tail = TAIL_DONE;
               end else if (in_byte == "\\") begin
                  phase_in = PH_ESC;
               end else begin
                  run = one_byte(in_byte);
               end
            end
            PH_ESC: begin
               phase_in = PH_BODY;
               case (in_byte)
                  "\"", "\\", "/": run = one_byte(in_byte);
                  "b": run = one_byte(8'h08);
                  "f": run = one_byte(8'h0c);
                  "n": run = one_byte(8'h0a);
                  "r": run = one_byte(8'h0d);
                  "t": run = one_byte(8'h09);
                  "u": begin
                     phase_in = PH_HEX1;
                     acc_in   = '0;
                     cnt_in   = '0;
                  end
                  default: begin
                     phase_in = PH_HALT;
                     run.tail = TAIL_ERROR;
                  end
               endcase
            end
            PH_HEX1, PH_HEX2: begin
               if (!digit_ok) begin
                  phase_in = PH_HALT;
                  run.tail = TAIL_ERROR;
               end else begin
                  acc_in = acc_new;
                  if (cnt_ff != 2'd3) begin
                     cnt_in = cnt_ff + 2'd1;
                  end else begin
                     cnt_in = '0;
                     if (phase_ff == PH_HEX1) begin
                        if (acc_new >= 16'hd800 && acc_new <= 16'hdbff) begin
                           hs_in    = acc_new[9:0];
                           phase_in = PH_NEED_BS;
                        end else begin
                           phase_in = PH_BODY;
                           run      = utf8_run({5'b0, acc_new});
                        end
                     end else if (acc_new < 16'hdc00 || acc_new > 16'hdfff) begin
                        phase_in = PH_HALT;
                        run.tail = TAIL_ERROR;
                     end else begin
                        phase_in = PH_BODY;
                        run      = utf8_run(21'h10000 + {1'b0, hs_ff, acc_new[9:0]});
                     end
                  end
               end
            end
            PH_NEED_BS: begin
               if (in_byte == "\\") begin
                  phase_in = PH_NEED_U;
               end else begin
                  phase_in = PH_HALT;
                  run.tail = TAIL_ERROR;
               end
            end
            PH_NEED_U: begin
               if (in_byte == "u") begin
                  phase_in = PH_HEX2;
                  acc_in   = '0;
                  cnt_in   = '0;
               end else begin
                  phase_in = PH_HALT;
                  run.tail = TAIL_ERROR;
               end
            end
            default: phase_in = PH_HALT;
         endcase
      end
      // close an unfinished string at end of text
      if (end_of_text && phase_in != PH_HALT) begin
         phase_in = PH_HALT;
         run.tail = TAIL_ERROR;
      end
   end

   assign run_push = accept && (run.nbytes != 3'd0 || run.tail != TAIL_NONE);

   // advance parser state on each accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HALT;
         acc_ff   <= '0;
         cnt_ff   <= '0;
         hs_ff    <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         cnt_ff   <= cnt_in;
         hs_ff    <= hs_in;
      end
   end

endmodule

### design/jsu_queue.sv
module jsu_queue
   import jsu_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  run_type push_run,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output run_type head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   run_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ff, wr_in;
   logic [PTR_W-1:0]   rd_ff, rd_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   assign full  = (cnt_ff == FULL_CNT);
   assign empty = (cnt_ff == '0);
   assign head  = mem_ff[rd_ff];

   // step pointers with wrap and track fill
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == LAST_PTR) ? '0 : wr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == LAST_PTR) ? '0 : rd_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // store the run
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_run;
      end
   end

endmodule

### design/jsu_back.sv
module jsu_back
   import jsu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  run_type    head,
   input  logic       head_empty,
   output logic       head_pop,
   output logic [7:0] out_byte,
   output logic [1:0] result_kind,
   output logic       last_of_run,
   input  logic       pop
);

   logic [2:0] idx_ff, idx_in;
   logic [2:0] total;
   logic       take;

   assign total = head.nbytes + ((head.tail != TAIL_NONE) ? 3'd1 : 3'd0);
   assign take  = pop && !head_empty;

   // select the result at the current index of the head run
   always_comb begin
      out_byte    = 8'd0;
      result_kind = KIND_DATA;
      if (idx_ff < head.nbytes) begin
         out_byte = head.bytes[idx_ff[1:0]];
      end else if (head.tail == TAIL_DONE) begin
         result_kind = KIND_DONE;
      end else begin
         result_kind = KIND_ERROR;
      end
   end

   assign last_of_run = (idx_ff == total - 3'd1);
   assign head_pop    = take && last_of_run;
   assign idx_in      = head_pop ? 3'd0 : idx_ff + 3'd1;

   // advance through the run one word per pop
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else if (take) begin
         idx_ff <= idx_in;
      end
   end

endmodule

### verif/json_string_unescape_utf8_test.sv
module json_string_unescape_utf8_test;
   import jsu_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 20;
   localparam int HOLD_CYCLES  = 300;

   // characters with a meaning to the decoder
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5c;
   localparam logic [7:0] CH_SLASH  = 8'h2f;
   localparam logic [7:0] CH_B      = 8'h62;
   localparam logic [7:0] CH_F      = 8'h66;
   localparam logic [7:0] CH_N      = 8'h6e;
   localparam logic [7:0] CH_R      = 8'h72;
   localparam logic [7:0] CH_T      = 8'h74;
   localparam logic [7:0] CH_U      = 8'h75;

   typedef enum logic [2:0] {
      DEC_HALT,
      DEC_BODY,
      DEC_ESC,
      DEC_HEX1,
      DEC_NEED_BS,
      DEC_NEED_U,
      DEC_HEX2
   } dec_phase_type;

   // ways a random string is broken
   typedef enum int {
      FLT_NONE,
      FLT_BAD_ESC,
      FLT_BAD_HEX,
      FLT_NO_LOW,
      FLT_CUT,
      FLT_RESTART,
      FLT_BAD_START,
      FLT_NOISE
   } fault_kind_type;

   typedef struct packed {
      logic [7:0] data;
      logic [1:0] kind;
      logic       last;
   } result_word_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic [7:0] req_in_byte = 8'h00;
   logic       req_start_of_string = 1'b0;
   logic       req_end_of_text = 1'b0;
   logic       req_push = 1'b0;
   logic       req_full;
   logic [7:0] rsp_out_byte;
   logic [1:0] rsp_result_kind;
   logic       rsp_last_of_run;
   logic       rsp_empty;
   logic       rsp_pop = 1'b0;

   // decoder mirror
   dec_phase_type   dec_phase = DEC_HALT;
   logic [15:0]     hex_acc = '0;
   logic [1:0]      hex_cnt = '0;
   logic [9:0]      hi_bits = '0;
   result_word_type run_words[$];
   result_word_type pending_words[$];

   logic [7:0] text_q[$];
   int  errors = 0;
   int  items_sent = 0;
   int  cycles = 0;
   bit  tx_idle_on = 1'b0;
   bit  rx_idle_on = 1'b0;
   int  hold_request = 0;

   json_string_unescape_utf8 u_top (
      .clock               (clock),
      .reset               (reset),
      .req_in_byte         (req_in_byte),
      .req_start_of_string (req_start_of_string),
      .req_end_of_text     (req_end_of_text),
      .req_push            (req_push),
      .req_full            (req_full),
      .rsp_out_byte        (rsp_out_byte),
      .rsp_result_kind     (rsp_result_kind),
      .rsp_last_of_run     (rsp_last_of_run),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic int nibble_of(input logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
      if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
      if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
      return -1;
   endfunction

   function automatic bit is_escape_char(input logic [7:0] c);
      case (c)
         CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T, CH_U: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   function automatic void add_word(input logic [7:0] b, input logic [1:0] k);
      result_word_type w;
      w.data = b;
      w.kind = k;
      w.last = 1'b0;
      run_words = {run_words, w};
   endfunction

   // append one byte to the text being built
   function automatic void add_text(input logic [7:0] b);
      text_q = {text_q, b};
   endfunction

   // encode one code point as UTF-8 data words
   function automatic void add_utf8(input logic [20:0] cp);
      if (cp <= 21'h7f) begin
         add_word(cp[7:0], KIND_DATA);
      end else if (cp <= 21'h7ff) begin
         add_word({3'b110, cp[10:6]}, KIND_DATA);
         add_word({2'b10, cp[5:0]}, KIND_DATA);
      end else if (cp <= 21'hffff) begin
         add_word({4'b1110, cp[15:12]}, KIND_DATA);
         add_word({2'b10, cp[11:6]}, KIND_DATA);
         add_word({2'b10, cp[5:0]}, KIND_DATA);
      end else begin
         add_word({5'b11110, cp[20:18]}, KIND_DATA);
         add_word({2'b10, cp[17:12]}, KIND_DATA);
         add_word({2'b10, cp[11:6]}, KIND_DATA);
         add_word({2'b10, cp[5:0]}, KIND_DATA);
      end
   endfunction

   // advance the decoder mirror by one accepted byte and queue its words
   function automatic void decode_byte(input logic [7:0] c, input logic sos, input logic eot);
      int d;
      run_words.delete();
      if (sos) begin
         hex_acc = '0;
         hex_cnt = '0;
         hi_bits = '0;
         if (c == CH_QUOTE) begin
            dec_phase = DEC_BODY;
         end else begin
            dec_phase = DEC_HALT;
            add_word(8'h00, KIND_ERROR);
         end
      end else begin
         case (dec_phase)
            DEC_BODY: begin
               if (c == CH_QUOTE) begin
                  dec_phase = DEC_HALT;
                  add_word(8'h00, KIND_DONE);
               end else if (c == CH_BSLASH) begin
                  dec_phase = DEC_ESC;
               end else begin
                  add_word(c, KIND_DATA);
               end
            end
            DEC_ESC: begin
               dec_phase = DEC_BODY;
               case (c)
                  CH_QUOTE, CH_BSLASH, CH_SLASH: add_word(c, KIND_DATA);
                  CH_B: add_word(8'h08, KIND_DATA);
                  CH_F: add_word(8'h0c, KIND_DATA);
                  CH_N: add_word(8'h0a, KIND_DATA);
                  CH_R: add_word(8'h0d, KIND_DATA);
                  CH_T: add_word(8'h09, KIND_DATA);
                  CH_U: begin
                     dec_phase = DEC_HEX1;
                     hex_acc = '0;
                     hex_cnt = '0;
                  end
                  default: begin
                     dec_phase = DEC_HALT;
                     add_word(8'h00, KIND_ERROR);
                  end
               endcase
            end
            DEC_HEX1, DEC_HEX2: begin
               d = nibble_of(c);
               if (d < 0) begin
                  dec_phase = DEC_HALT;
                  add_word(8'h00, KIND_ERROR);
               end else begin
                  hex_acc = {hex_acc[11:0], d[3:0]};
                  if (hex_cnt < 2'd3) begin
                     hex_cnt = hex_cnt + 2'd1;
                  end else begin
                     hex_cnt = '0;
                     if (dec_phase == DEC_HEX1) begin
                        if (hex_acc >= 16'hd800 && hex_acc <= 16'hdbff) begin
                           hi_bits = hex_acc[9:0];
                           dec_phase = DEC_NEED_BS;
                        end else begin
                           dec_phase = DEC_BODY;
                           add_utf8({5'd0, hex_acc});
                        end
                     end else if (hex_acc < 16'hdc00 || hex_acc > 16'hdfff) begin
                        dec_phase = DEC_HALT;
                        add_word(8'h00, KIND_ERROR);
                     end else begin
                        dec_phase = DEC_BODY;
                        add_utf8(21'h10000 + {1'b0, hi_bits, hex_acc[9:0]});
                     end
                  end
               end
            end
            DEC_NEED_BS: begin
               if (c == CH_BSLASH) begin
                  dec_phase = DEC_NEED_U;
               end else begin
                  dec_phase = DEC_HALT;
                  add_word(8'h00, KIND_ERROR);
               end
            end
            DEC_NEED_U: begin
               if (c == CH_U) begin
                  dec_phase = DEC_HEX2;
                  hex_acc = '0;
                  hex_cnt = '0;
               end else begin
                  dec_phase = DEC_HALT;
                  add_word(8'h00, KIND_ERROR);
               end
            end
            default: dec_phase = DEC_HALT;
         endcase
      end
      // text ended with the string still open
      if (eot && dec_phase != DEC_HALT) begin
         dec_phase = DEC_HALT;
         add_word(8'h00, KIND_ERROR);
      end
      if (run_words.size() > 0) run_words[run_words.size() - 1].last = 1'b1;
      pending_words = {pending_words, run_words};
   endfunction

   // watch both handshakes: predict on accepted bytes, check popped words
   initial begin
      result_word_type got;
      result_word_type want;
      forever begin
         @(posedge clock);
         if (reset) begin
            dec_phase = DEC_HALT;
            hex_acc = '0;
            hex_cnt = '0;
            hi_bits = '0;
         end else begin
            if (req_push && !req_full)
               decode_byte(req_in_byte, req_start_of_string, req_end_of_text);
            if (rsp_pop && !rsp_empty) begin
               got = {rsp_out_byte, rsp_result_kind, rsp_last_of_run};
               if (pending_words.size() == 0) begin
                  errors++;
                  $display("%0t: unexpected word, expected none, got byte %h kind %0d last %b",
                           $time, got.data, got.kind, got.last);
               end else begin
                  want = pending_words.pop_front();
                  if (got !== want) begin
                     errors++;
                     $display("%0t: word mismatch, expected %h %0d %b, got %h %0d %b",
                              $time, want.data, want.kind, want.last,
                              got.data, got.kind, got.last);
                  end
               end
            end
         end
      end
   end

   // receiver: random stall bursts, plus a long hold-off on request
   initial begin
      int hold_left;
      int stall_left;
      hold_left = 0;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else if (stall_left != 0) begin
            stall_left--;
            rsp_pop <= 1'b0;
         end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 16) - 1;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // watchdog
   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("json_string_unescape_utf8: mismatch");
      $finish;
   end

   // offer one byte, optionally after an idle burst, and wait until it is taken
   task automatic push_byte(input logic [7:0] b, input logic sos, input logic eot);
      int gap;
      gap = (tx_idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
      if (gap != 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_in_byte <= b;
      req_start_of_string <= sos;
      req_end_of_text <= eot;
      req_push <= 1'b1;
      @(posedge clock);
      while (req_full) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_text(input string s, input bit sos_first, input bit eot_last);
      int i;
      for (i = 0; i < s.len(); i++)
         push_byte(s[i], sos_first && i == 0, eot_last && i == s.len() - 1);
   endtask

   function automatic logic [7:0] hex_char(input logic [3:0] v);
      if (v < 4'd10) return 8'h30 + 8'(v);
      return (($urandom_range(0, 1) != 0) ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
   endfunction

   function automatic void put_u_escape(input logic [15:0] v);
      add_text(CH_BSLASH);
      add_text(CH_U);
      add_text(hex_char(v[15:12]));
      add_text(hex_char(v[11:8]));
      add_text(hex_char(v[7:4]));
      add_text(hex_char(v[3:0]));
   endfunction

   function automatic logic [7:0] rand_non_hex();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      while (nibble_of(b) >= 0) b = 8'($urandom_range(0, 255));
      return b;
   endfunction

   // append one well-formed piece of string body
   function automatic void put_token();
      logic [7:0] b;
      logic [15:0] v;
      logic [7:0] esc_set[8];
      esc_set = '{CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T};
      case ($urandom_range(0, 5))
         0, 1: begin
            b = 8'($urandom_range(0, 255));
            while (b == CH_QUOTE || b == CH_BSLASH) b = 8'($urandom_range(0, 255));
            add_text(b);
         end
         2: begin
            add_text(CH_BSLASH);
            add_text(esc_set[3'($urandom_range(0, 7))]);
         end
         3: put_u_escape(16'($urandom_range(0, 16'h07ff)));
         4: begin
            v = 16'($urandom_range(16'h0800, 16'hffff));
            // high surrogates become lone low ones
            if (v >= 16'hd800 && v <= 16'hdbff) v = v ^ 16'h0400;
            put_u_escape(v);
         end
         default: begin
            put_u_escape(16'($urandom_range(16'hd800, 16'hdbff)));
            put_u_escape(16'($urandom_range(16'hdc00, 16'hdfff)));
         end
      endcase
   endfunction

   // build one string, well-formed or broken in one way, and send it
   task automatic send_random_string();
      fault_kind_type fault;
      int ntok, fault_tok, sos_at, restart_at, eot_at, t, i;
      logic [7:0] b;
      logic [15:0] v;
      text_q.delete();
      fault = ($urandom_range(0, 9) < 6) ? FLT_NONE : fault_kind_type'($urandom_range(1, 7));
      restart_at = -1;
      if (fault == FLT_NOISE)
         repeat ($urandom_range(1, 3)) add_text(8'($urandom_range(0, 255)));
      sos_at = text_q.size();
      if (fault == FLT_BAD_START) begin
         b = 8'($urandom_range(0, 255));
         while (b == CH_QUOTE) b = 8'($urandom_range(0, 255));
         add_text(b);
      end else begin
         add_text(CH_QUOTE);
      end
      ntok = $urandom_range(0, 8);
      fault_tok = $urandom_range(0, ntok);
      for (t = 0; t <= ntok; t++) begin
         if (t == fault_tok) begin
            case (fault)
               FLT_BAD_ESC: begin
                  b = 8'($urandom_range(0, 255));
                  while (is_escape_char(b)) b = 8'($urandom_range(0, 255));
                  add_text(CH_BSLASH);
                  add_text(b);
               end
               FLT_BAD_HEX: begin
                  add_text(CH_BSLASH);
                  add_text(CH_U);
                  repeat ($urandom_range(0, 3)) add_text(hex_char(4'($urandom_range(0, 15))));
                  add_text(rand_non_hex());
               end
               FLT_NO_LOW: begin
                  put_u_escape(16'($urandom_range(16'hd800, 16'hdbff)));
                  case ($urandom_range(0, 2))
                     0: begin
                        b = 8'($urandom_range(0, 255));
                        while (b == CH_BSLASH) b = 8'($urandom_range(0, 255));
                        add_text(b);
                     end
                     1: begin
                        b = 8'($urandom_range(0, 255));
                        while (b == CH_U) b = 8'($urandom_range(0, 255));
                        add_text(CH_BSLASH);
                        add_text(b);
                     end
                     default: begin
                        v = 16'($urandom_range(0, 16'hffff));
                        while (v >= 16'hdc00 && v <= 16'hdfff)
                           v = 16'($urandom_range(0, 16'hffff));
                        put_u_escape(v);
                     end
                  endcase
               end
               FLT_RESTART: begin
                  restart_at = text_q.size();
                  add_text($urandom_range(0, 1) ? CH_QUOTE : 8'($urandom_range(0, 255)));
               end
               default: ;
            endcase
         end
         if (t < ntok) put_token();
      end
      add_text(CH_QUOTE);
      if (fault == FLT_CUT)
         eot_at = $urandom_range(sos_at, text_q.size() - 2);
      else
         eot_at = ($urandom_range(0, 3) == 0) ? text_q.size() - 1 : -1;
      for (i = 0; i < text_q.size(); i++)
         push_byte(text_q[i], i == sos_at || i == restart_at, i == eot_at);
   endtask

   task automatic test_plain_bytes();
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
      // halted: no result
      push_byte(8'h78, 1'b0, 1'b0);
      push_byte(CH_QUOTE, 1'b1, 1'b0);
      push_byte(8'h00, 1'b0, 1'b0);
      push_byte(8'hff, 1'b0, 1'b0);
      push_byte(8'h80, 1'b0, 1'b0);
      push_byte(8'h7f, 1'b0, 1'b0);
      // closing quote with end of text gives done only
      push_byte(CH_QUOTE, 1'b0, 1'b1);
   endtask

   task automatic test_escapes();
      // every short escape, then an unknown one
      send_text("\"\\\"\\\\\\/\\b\\f\\n\\r\\t\\q", 1'b1, 1'b0);
   endtask

   task automatic test_unicode();
      // BMP extremes, lone low, pairs; text ends on the last digit: four bytes and an error
      send_text("\"\\u0000\\u007F\\u0080\\u07fF\\uFFFF\\udc00\\uD800\\uDC00\\udbff\\udfff",
                1'b1, 1'b1);
   endtask

   task automatic test_errors();
      send_text("\"\\u0g", 1'b1, 1'b0);
      send_text("\"\\ud800x", 1'b1, 1'b0);
      send_text("\"\\ud800\\x", 1'b1, 1'b0);
      send_text("\"\\ud800\\u0041", 1'b1, 1'b0);
      // ignored after the error
      push_byte(8'h79, 1'b0, 1'b0);
      // restart on a byte that is not a quote
      send_text("\"ab", 1'b1, 1'b0);
      push_byte(8'h61, 1'b1, 1'b0);
      // opening quote that is also the end of text
      push_byte(CH_QUOTE, 1'b1, 1'b1);
      // restart abandons an open string
      send_text("\"a", 1'b1, 1'b0);
      push_byte(CH_QUOTE, 1'b1, 1'b0);
      push_byte(CH_QUOTE, 1'b0, 1'b0);
   endtask

   task automatic test_full_backpressure();
      tx_idle_on = 1'b0;
      hold_request = HOLD_CYCLES;
      // long runs back to back while the receiver holds off
      text_q.delete();
      add_text(CH_QUOTE);
      repeat (2) begin
         put_u_escape(16'($urandom_range(16'hd800, 16'hdbff)));
         put_u_escape(16'($urandom_range(16'hdc00, 16'hdfff)));
         add_text(8'h41);
      end
      add_text(CH_QUOTE);
      foreach (text_q[i]) push_byte(text_q[i], i == 0, 1'b0);
   endtask

   task automatic test_random_strings();
      int stop_at;
      stop_at = items_sent + 40;
      while (items_sent < stop_at) begin
         tx_idle_on = ($urandom_range(0, 2) != 0);
         rx_idle_on = ($urandom_range(0, 2) != 0);
         send_random_string();
      end
   endtask

   task automatic test_streaming();
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
      repeat (2) send_random_string();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_plain_bytes();
      test_escapes();
      test_unicode();
      test_errors();
      test_full_backpressure();
      test_random_strings();
      test_streaming();
      req_push <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0 && pending_words.size() == 0)
         $display("json_string_unescape_utf8: match");
      else
         $display("json_string_unescape_utf8: mismatch");
      $finish;
   end

endmodule

### json_string_unescape_utf8.f
design/jsu_pkg.sv
design/jsu_front.sv
design/jsu_queue.sv
design/jsu_back.sv
design/json_string_unescape_utf8.sv
verif/json_string_unescape_utf8_test.sv
